/* hdl/segclip_pkg.sv */
// Shared types, widths and constants of the segment rectangle clipper.
package segclip_pkg;

  // Coordinate and parameter formats
  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 4;
  localparam int CFG_W      = 11;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int EDGE_W     = COORD_W + 2;
  localparam int NUM_W      = 16;
  localparam int DEN_W      = 16;
  localparam int T_FRAC     = 16;
  localparam int T_W        = 32;
  localparam int DIV_W      = NUM_W + T_FRAC;
  localparam int PROD_W     = T_W + DELTA_W;
  localparam int SP_W       = DELTA_W + EDGE_W;
  localparam int NUM_T      = 6;
  localparam int RANK_W     = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // Register map (index is byte address / 4)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(5);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(3);

  typedef logic signed [T_W-1:0] tpar_t;
  typedef logic [NUM_T-1:0][T_W-1:0] tvec_t;

  localparam tpar_t T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam tpar_t T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam tpar_t T_ONE = tpar_t'(1) <<< T_FRAC;

  // Per-item data that rides alongside the crossing dividers
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [3:0]                neg;
    logic                      vis_ok;
  } side_t;

  // One clipped result
  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } res_t;

  function automatic logic [NUM_W-1:0] edge_mag(input logic signed [EDGE_W-1:0] v);
    logic signed [EDGE_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[NUM_W-1:0];
  endfunction

  function automatic logic [DEN_W-1:0] delta_mag(input logic signed [DELTA_W-1:0] v);
    logic signed [DELTA_W-1:0] a;
    a = (v < 0) ? -v : v;
    return a[DEN_W-1:0];
  endfunction

endpackage

/* hdl/segclip_divider.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module segclip_divider (
  input  logic                          clk,
  input  logic                          en,
  input  logic [segclip_pkg::DIV_W-1:0] num_i,
  input  logic [segclip_pkg::DEN_W-1:0] den_i,
  output logic [segclip_pkg::DIV_W-1:0] quo_o
);
  import segclip_pkg::*;

  logic [DEN_W-1:0] rem_r [DIV_W];
  logic [DIV_W-1:0] num_r [DIV_W];
  logic [DEN_W-1:0] den_r [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in, rem_nxt, den_in;
    logic [DIV_W-1:0] num_in, num_nxt;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Stage input: ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
    end

    // Shift in next numerator bit, subtract if it fits
    always_comb begin
      trial   = {rem_in, num_in[DIV_W-1]};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      num_nxt = {num_in[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        den_r[k] <= den_in;
      end
    end
  end

  // Numerator register has become the quotient after the last stage
  assign quo_o = num_r[DIV_W-1];

endmodule

/* hdl/segclip_rank_select.sv */
// Two-stage rank sort of six parameters, picks the third and fourth smallest.
module segclip_rank_select (
  input  logic                clk,
  input  logic                en,
  input  segclip_pkg::tvec_t  t_i,
  output segclip_pkg::tpar_t  entry_o,
  output segclip_pkg::tpar_t  exit_o
);
  import segclip_pkg::*;

  tvec_t              t_r;
  logic [NUM_T-1:0][NUM_T-1:0] bef_r, bef_nxt;
  tpar_t              entry_r, exit_r, entry_nxt, exit_nxt;
  logic [RANK_W-1:0]  rank;

  // Pairwise order, ties broken by position
  always_comb begin
    for (int i = 0; i < NUM_T; i++) begin
      for (int j = 0; j < NUM_T; j++) begin
        if (j < i) bef_nxt[i][j] = $signed(t_i[j]) <= $signed(t_i[i]);
        else if (j > i) bef_nxt[i][j] = $signed(t_i[j]) < $signed(t_i[i]);
        else bef_nxt[i][j] = 1'b0;
      end
    end
  end

  // Rank count and selection of the middle pair
  always_comb begin
    entry_nxt = '0;
    exit_nxt  = '0;
    rank      = '0;
    for (int i = 0; i < NUM_T; i++) begin
      rank = '0;
      for (int j = 0; j < NUM_T; j++) rank = rank + RANK_W'(bef_r[i][j]);
      if (rank == RANK_W'(2)) entry_nxt = t_r[i];
      if (rank == RANK_W'(3)) exit_nxt = t_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_i;
      bef_r   <= bef_nxt;
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
    end
  end

  assign entry_o = entry_r;
  assign exit_o  = exit_r;

endmodule

/* hdl/segclip_interp.sv */
// Clipped point interpolation: multiply stage, then truncate, add and saturate.
module segclip_interp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_i,
  input  segclip_pkg::tpar_t  entry_i,
  input  segclip_pkg::tpar_t  exit_i,
  input  segclip_pkg::side_t  side_i,
  output logic                v_o,
  output segclip_pkg::res_t   res_o
);
  import segclip_pkg::*;

  logic                      v_r;
  logic                      vis_r, vis_nxt;
  logic signed [PROD_W-1:0]  prod_r [4];
  logic signed [PROD_W-1:0]  prod_nxt [4];
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_W-1:0] pt [4];

  // Visibility and products t * delta
  always_comb begin
    vis_nxt = side_i.vis_ok && !(($signed(entry_i) >= T_ONE) || ($signed(exit_i) <= 0));
    prod_nxt[0] = PROD_W'(entry_i) * PROD_W'(side_i.dx);
    prod_nxt[1] = PROD_W'(entry_i) * PROD_W'(side_i.dy);
    prod_nxt[2] = PROD_W'(exit_i) * PROD_W'(side_i.dx);
    prod_nxt[3] = PROD_W'(exit_i) * PROD_W'(side_i.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r <= vis_nxt;
      for (int k = 0; k < 4; k++) prod_r[k] <= prod_nxt[k];
      ax_r <= side_i.ax;
      ay_r <= side_i.ay;
      bx_r <= COORD_W'(DELTA_W'(side_i.ax) + side_i.dx);
      by_r <= COORD_W'(DELTA_W'(side_i.ay) + side_i.dy);
    end
  end

  // Truncate toward zero, add origin, saturate to coordinate range
  always_comb begin
    logic signed [PROD_W-1:0]        biased;
    logic signed [PROD_W-T_FRAC-1:0] q;
    logic signed [PROD_W-T_FRAC:0]   s;
    for (int k = 0; k < 4; k++) begin
      biased = prod_r[k] + (prod_r[k][PROD_W-1] ? PROD_W'((1 << T_FRAC) - 1) : '0);
      q = biased[PROD_W-1:T_FRAC];
      s = (PROD_W-T_FRAC+1)'((k % 2 == 0) ? ax_r : ay_r) + (PROD_W-T_FRAC+1)'(q);
      if (s > (PROD_W-T_FRAC+1)'(32767)) pt[k] = 16'sh7FFF;
      else if (s < -(PROD_W-T_FRAC+1)'(32768)) pt[k] = 16'sh8000;
      else pt[k] = s[COORD_W-1:0];
    end
  end

  always_comb begin
    res_o.visible = vis_r;
    res_o.sx = vis_r ? pt[0] : ax_r;
    res_o.sy = vis_r ? pt[1] : ay_r;
    res_o.ex = vis_r ? pt[2] : bx_r;
    res_o.ey = vis_r ? pt[3] : by_r;
  end

  assign v_o = v_r;

endmodule

/* hdl/segment_rectangle_clipper_unit.sv */
// Pipeline from input transaction to out_tvalid: 2 setup stages, 32 divider stages
// one quotient bit each, 3 sort stages, then interpolation and the output register.
// Throughput: one segment per cycle while the pipeline is not halted; the divider pipeline sets the depth.
// Output register plus one skid entry; the pipeline halts only while the skid is full.
// Reset (rst_n low, synchronous) empties the pipeline; width 5, height 3.
module segment_rectangle_clipper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic        out_tuser,  // visible
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [segclip_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [segclip_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [segclip_pkg::PDATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);
  import segclip_pkg::*;

  logic en;

  // Configuration registers
  logic [CFG_W-1:0] width_r, height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) width_r <= cfg_pwdata[CFG_W-1:0];
      else height_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_WIDTH) ? PDATA_W'(width_r) : PDATA_W'(height_r);

  // Stage 1: deltas and offsets to the far edges
  logic                      s1_v_r;
  logic signed [COORD_W-1:0] s1_ax_r, s1_ay_r;
  logic signed [DELTA_W-1:0] s1_dx_r, s1_dy_r;
  logic signed [EDGE_W-1:0]  s1_ex_r, s1_ey_r;
  logic signed [COORD_W-1:0] in_ax, in_ay, in_bx, in_by;
  logic signed [EDGE_W-1:0]  w_fix, h_fix;

  assign in_ax = in_tdata[15:0];
  assign in_ay = in_tdata[31:16];
  assign in_bx = in_tdata[47:32];
  assign in_by = in_tdata[63:48];
  assign w_fix = $signed(EDGE_W'({width_r, COORD_FRAC'(0)}));
  assign h_fix = $signed(EDGE_W'({height_r, COORD_FRAC'(0)}));

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r <= in_ax;
      s1_ay_r <= in_ay;
      s1_dx_r <= DELTA_W'(in_bx) - DELTA_W'(in_ax);
      s1_dy_r <= DELTA_W'(in_by) - DELTA_W'(in_ay);
      s1_ex_r <= EDGE_W'(in_ax) - w_fix;
      s1_ey_r <= EDGE_W'(in_ay) - h_fix;
    end
  end

  // Stage 2: divider operands and line-side products
  logic                     s2_v_r;
  side_t                    s2_side_r;
  logic [DIV_W-1:0]         s2_num_r [4];
  logic [DEN_W-1:0]         s2_den_r [4];
  logic signed [SP_W-1:0]   p_ax_r, p_ex_r, p_ay_r, p_ey_r;
  logic signed [EDGE_W-1:0] nm [4];

  always_comb begin
    nm[0] = -EDGE_W'(s1_ax_r);
    nm[1] = -s1_ex_r;
    nm[2] = -EDGE_W'(s1_ay_r);
    nm[3] = -s1_ey_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r.ax <= s1_ax_r;
      s2_side_r.ay <= s1_ay_r;
      s2_side_r.dx <= s1_dx_r;
      s2_side_r.dy <= s1_dy_r;
      s2_side_r.vis_ok <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        s2_num_r[k] <= {edge_mag(nm[k]), T_FRAC'(0)};
        s2_den_r[k] <= delta_mag((k < 2) ? s1_dx_r : s1_dy_r);
        s2_side_r.neg[k] <= nm[k][EDGE_W-1] ^ ((k < 2) ? s1_dx_r[DELTA_W-1]
                                                      : s1_dy_r[DELTA_W-1]);
      end
      p_ax_r <= SP_W'(s1_dy_r) * SP_W'(s1_ax_r);
      p_ex_r <= SP_W'(s1_dy_r) * SP_W'(s1_ex_r);
      p_ay_r <= SP_W'(s1_dx_r) * SP_W'(s1_ay_r);
      p_ey_r <= SP_W'(s1_dx_r) * SP_W'(s1_ey_r);
    end
  end

  // Line-side test against the four corners
  logic signed [SP_W:0] csum [4];
  logic [1:0]           csgn [4];
  logic                 vis_ok;

  always_comb begin
    csum[0] = (SP_W+1)'(p_ay_r) - (SP_W+1)'(p_ax_r);
    csum[1] = (SP_W+1)'(p_ay_r) - (SP_W+1)'(p_ex_r);
    csum[2] = (SP_W+1)'(p_ey_r) - (SP_W+1)'(p_ax_r);
    csum[3] = (SP_W+1)'(p_ey_r) - (SP_W+1)'(p_ex_r);
    for (int k = 0; k < 4; k++) csgn[k] = {csum[k][SP_W], csum[k] == '0};
    vis_ok = !((csgn[0] == csgn[1]) && (csgn[0] == csgn[2]) && (csgn[0] == csgn[3]));
  end

  // Crossing dividers
  logic [DIV_W-1:0] quo [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    segclip_divider u_div (
      .clk   (clk),
      .en    (en),
      .num_i (s2_num_r[k]),
      .den_i (s2_den_r[k]),
      .quo_o (quo[k])
    );
  end

  // Side data delay line matching the divider depth
  logic  dly_v_r [DIV_W];
  side_t dly_r   [DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_W; k++) dly_v_r[k] <= 1'b0;
    end else if (en) begin
      dly_v_r[0] <= s2_v_r;
      for (int k = 1; k < DIV_W; k++) dly_v_r[k] <= dly_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= '{ax: s2_side_r.ax, ay: s2_side_r.ay, dx: s2_side_r.dx,
                    dy: s2_side_r.dy, neg: s2_side_r.neg, vis_ok: vis_ok};
      for (int k = 1; k < DIV_W; k++) dly_r[k] <= dly_r[k-1];
    end
  end

  // Saturate crossings, substitute extremes on zero delta
  side_t tail_side;
  tvec_t t_nxt, t_r;
  logic  t_v_r;
  side_t t_side_r;

  assign tail_side = dly_r[DIV_W-1];

  always_comb begin
    tpar_t c [4];
    for (int k = 0; k < 4; k++) begin
      if (tail_side.neg[k]) begin
        if (quo[k][DIV_W-1] && (|quo[k][DIV_W-2:0])) c[k] = T_MIN;
        else c[k] = T_W'(-$signed({1'b0, quo[k]}));
      end else begin
        c[k] = quo[k][DIV_W-1] ? T_MAX : $signed(quo[k]);
      end
    end
    if (tail_side.dx == '0) begin
      c[0] = T_MIN;
      c[1] = T_MAX;
    end
    if (tail_side.dy == '0) begin
      c[2] = T_MIN;
      c[3] = T_MAX;
    end
    t_nxt[0] = '0;
    t_nxt[1] = T_ONE;
    t_nxt[2] = c[0];
    t_nxt[3] = c[1];
    t_nxt[4] = c[2];
    t_nxt[5] = c[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) t_v_r <= 1'b0;
    else if (en) t_v_r <= dly_v_r[DIV_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= t_nxt;
      t_side_r <= tail_side;
    end
  end

  // Sort and middle-pair selection
  tpar_t entry, exit_t;
  logic  r_v_r [2];
  side_t r_side_r [2];

  segclip_rank_select u_rank (
    .clk     (clk),
    .en      (en),
    .t_i     (t_r),
    .entry_o (entry),
    .exit_o  (exit_t)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r[0] <= 1'b0;
      r_v_r[1] <= 1'b0;
    end else if (en) begin
      r_v_r[0] <= t_v_r;
      r_v_r[1] <= r_v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_side_r[0] <= t_side_r;
      r_side_r[1] <= r_side_r[0];
    end
  end

  // Interpolation
  logic pipe_v;
  res_t pipe_res;

  segclip_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_i     (r_v_r[1]),
    .entry_i (entry),
    .exit_i  (exit_t),
    .side_i  (r_side_r[1]),
    .v_o     (pipe_v),
    .res_o   (pipe_res)
  );

  // Output register with skid entry
  logic out_v_r, skid_v_r;
  res_t out_r, skid_r;
  logic pipe_take;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign pipe_take = pipe_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || pipe_take;
      skid_v_r <= 1'b0;
    end else if (pipe_take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : pipe_res;
    end else if (pipe_take) begin
      skid_r <= pipe_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.visible;
  assign out_tdata  = {out_r.ey, out_r.ex, out_r.sy, out_r.sx};

  // Skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry filled while output register empty");

  // Skid fills only when a result was stalled and the pipeline delivered
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && pipe_v))
    else $error("skid filled without a stalled result");

  // A pipeline result moving out always shows up at the output
  a_pipe_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_take |=> out_v_r)
    else $error("pipeline result lost");

endmodule
